>>> rtl/lru_page_replacement_macros.svh
// Assertion macros shared by the LRU page replacement RTL.
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// Same-cycle implication, sampled on clk and held off while rst is high.
`define LRUPR_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off while rst is high.
`define LRUPR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lrupr_pkg.sv
// Shared types and constants for the LRU page replacement block.
`timescale 1ns / 1ps

package lrupr_pkg;

  localparam int PAGE_W  = 20;
  localparam int FRAME_W = 3;
  localparam int LIMIT_W = 4;
  localparam int OUT_W   = 2;

  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [LIMIT_W-1:0] limit_t;
  typedef logic [OUT_W-1:0]   outcome_t;

  // Result outcome codes.
  localparam outcome_t OUTCOME_HIT     = 2'd0;
  localparam outcome_t OUTCOME_FILL    = 2'd1;
  localparam outcome_t OUTCOME_REPLACE = 2'd2;

  localparam limit_t LIMIT_RESET = 4'd8;

endpackage

>>> rtl/lru_page_replacement.sv
// LRU page replacement unit: recency list walk with a single compare-and-shift sequencer.
`timescale 1ns / 1ps
`include "lru_page_replacement_macros.svh"

//  Channel  Signals                                    Direction
//  -------  -----------------------------------------  ---------
//  in       in_valid, in_ready, page_number            request in
//  out      out_valid, out_ready, outcome, frame,      result out
//           evicted_page
//  cfg      cfg_valid, cfg_ready, frame_limit          write in
//
// A request walks the recency list until it hits or reaches the tail. An empty list
// skips the walk, and a filling miss passes through a tail step that moves the old
// tail back. The walk reads one entry per cycle through the memory's single read
// port. Reset empties the list at once: the resident count goes to zero and no memory
// sweep is needed. A stalled result waits in the output register; the next request is
// taken meanwhile and its walk only stops before the final write if the earlier
// result still has not been taken.

module lru_page_replacement #(
  parameter int FRAMES = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  lrupr_pkg::page_t          page_number,
  output logic                      out_valid,
  input  logic                      out_ready,
  output lrupr_pkg::outcome_t       outcome,
  output lrupr_pkg::frame_t         frame,
  output lrupr_pkg::page_t          evicted_page,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  lrupr_pkg::limit_t         frame_limit
);

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int CMP_W = (CNT_W > lrupr_pkg::LIMIT_W) ? CNT_W : lrupr_pkg::LIMIT_W;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_TAIL   = 2'd2;
  localparam logic [1:0] ST_FRONT  = 2'd3;

  logic [1:0]           state;
  logic [IDX_W-1:0]     idx;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     walk_len;
  lrupr_pkg::limit_t    limit_reg;

  lrupr_pkg::page_t     req_page;
  lrupr_pkg::page_t     carry_page;
  lrupr_pkg::frame_t    carry_frame;
  lrupr_pkg::outcome_t  work_outcome;
  lrupr_pkg::frame_t    work_frame;
  lrupr_pkg::page_t     work_evicted;

  // Recency list, front (most recent) at index 0.
  lrupr_pkg::page_t     page_mem  [FRAMES];
  lrupr_pkg::frame_t    frame_mem [FRAMES];
  lrupr_pkg::page_t     rd_page;
  lrupr_pkg::frame_t    rd_frame;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     wr_addr;
  logic                 wr_en;
  lrupr_pkg::page_t     wr_page;
  lrupr_pkg::frame_t    wr_frame;

  logic                 in_fire;
  logic                 out_free;
  logic                 out_load;
  logic                 hit;
  logic                 last;
  logic                 room;
  lrupr_pkg::limit_t    limit_eff;

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign out_load  = (state == ST_FRONT) && out_free;

  // A limit of zero behaves as one; the cap at FRAMES is applied in the room check.
  assign limit_eff = (limit_reg == '0) ? lrupr_pkg::limit_t'(1) : limit_reg;
  assign room      = (CMP_W'(walk_len) < CMP_W'(limit_eff)) &&
                     (walk_len < CNT_W'(FRAMES));

  assign hit  = (rd_page == req_page);
  assign last = (CNT_W'(idx) == walk_len - CNT_W'(1));

  // The walk reads one entry ahead of the one being compared.
  assign rd_addr = (state == ST_SEARCH) ? idx + IDX_W'(1) : '0;

  // Write side of the walk. While searching, each entry is overwritten with the one
  // in front of it, so the list shifts back by one as far as the hit or the tail.
  // On a filling miss the old tail moves one slot further, and the request's page
  // finally lands at the front.
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = idx;
    wr_page  = carry_page;
    wr_frame = carry_frame;
    unique case (state)
      ST_SEARCH: begin
        wr_en = (idx != '0);
      end
      ST_TAIL: begin
        wr_en   = 1'b1;
        wr_addr = walk_len[IDX_W-1:0];
      end
      ST_FRONT: begin
        wr_en    = out_free;
        wr_addr  = '0;
        wr_page  = req_page;
        wr_frame = work_frame;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      page_mem[wr_addr]  <= wr_page;
      frame_mem[wr_addr] <= wr_frame;
    end
    rd_page  <= page_mem[rd_addr];
    rd_frame <= frame_mem[rd_addr];
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_reg <= lrupr_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_reg <= frame_limit;
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // A new result replaces the one taken in the same cycle.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            idx      <= '0;
            walk_len <= count;
            req_page <= page_number;
            if (count == '0) begin
              // Empty list: the page takes frame zero straight away.
              work_outcome <= lrupr_pkg::OUTCOME_FILL;
              work_frame   <= '0;
              work_evicted <= '0;
              state        <= ST_FRONT;
            end else begin
              state <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          carry_page  <= rd_page;
          carry_frame <= rd_frame;
          if (hit) begin
            work_outcome <= lrupr_pkg::OUTCOME_HIT;
            work_frame   <= rd_frame;
            work_evicted <= '0;
            state        <= ST_FRONT;
          end else if (last) begin
            if (room) begin
              work_outcome <= lrupr_pkg::OUTCOME_FILL;
              work_frame   <= lrupr_pkg::frame_t'(walk_len);
              work_evicted <= '0;
              state        <= ST_TAIL;
            end else begin
              // The tail entry just read is the victim; its frame is reused.
              work_outcome <= lrupr_pkg::OUTCOME_REPLACE;
              work_frame   <= rd_frame;
              work_evicted <= rd_page;
              state        <= ST_FRONT;
            end
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        ST_TAIL: begin
          state <= ST_FRONT;
        end
        ST_FRONT: begin
          if (out_free) begin
            outcome      <= work_outcome;
            frame        <= work_frame;
            evicted_page <= work_evicted;
            if (work_outcome == lrupr_pkg::OUTCOME_FILL) begin
              count <= count + CNT_W'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The list never holds more pages than there are frames.
  `LRUPR_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(FRAMES), "resident count overflow")

  // An accepted request keeps the input side closed on the next cycle.
  `LRUPR_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready, "ready while walking")

  // Only a replacing miss reports an evicted page.
  `LRUPR_ASSERT_NOW(a_evict_zero,
    out_valid && (outcome != lrupr_pkg::OUTCOME_REPLACE), evicted_page == '0,
    "evicted page set without replacement")

  // A filling miss always hands out the frame equal to the old resident count.
  `LRUPR_ASSERT_NEXT(a_fill_frame,
    (state == ST_FRONT) && out_free && (work_outcome == lrupr_pkg::OUTCOME_FILL),
    frame == lrupr_pkg::frame_t'(count - CNT_W'(1)), "fill frame mismatch")

endmodule

>>> test/lru_page_replacement_test.sv
// Self-checking testbench for the LRU page replacement unit.
`timescale 1ns / 1ps

module lru_page_replacement_test;

  localparam int FRAMES = 8;
  localparam int POOL_N = 10;
  localparam int ROWS = 22;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASE_ITEMS = 250;
  localparam int CYCLE_LIMIT = 200000;

  // What one page request is expected to produce.
  typedef struct packed {
    lrupr_pkg::outcome_t outcome;
    lrupr_pkg::frame_t frame;
    lrupr_pkg::page_t evicted;
  } result_t;

  // A directed row either writes the frame limit or references a page. Rows
  // marked pinned carry a hand-written result; the others are predicted.
  typedef enum logic {ROW_PAGE, ROW_LIMIT} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    lrupr_pkg::limit_t limit;
    lrupr_pkg::page_t page;
    logic pinned;
    lrupr_pkg::outcome_t outcome;
    lrupr_pkg::frame_t frame;
    lrupr_pkg::page_t evicted;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  lrupr_pkg::page_t page_number = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lrupr_pkg::outcome_t outcome;
  lrupr_pkg::frame_t frame;
  lrupr_pkg::page_t evicted_page;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  lrupr_pkg::limit_t frame_limit = lrupr_pkg::LIMIT_RESET;

  // Travels with each page request so the checker knows when a row of the
  // table has fixed its own result.
  logic pin_valid = 1'b0;
  result_t pin_result = '0;

  // Mirror of the block's recency list, front entry is the most recent.
  lrupr_pkg::page_t resident_pages [FRAMES];
  lrupr_pkg::frame_t resident_frames [FRAMES];
  int resident_n;
  lrupr_pkg::limit_t limit_reg;

  result_t pending_lookups [$];
  int mismatches = 0;
  int cycle_count = 0;

  int tx_idle_pct = 20;
  int rx_idle_pct = 75;
  logic hold_requested = 1'b0;

  lrupr_pkg::page_t page_pool [POOL_N];

  // The directed part. It starts with a limit of zero, which has to behave
  // like a single frame, so every miss after the first one replaces. It then
  // raises the limit past the number of frames, which must saturate, fills
  // the list with the extreme page numbers, and replaces and hits at both
  // ends. Last, the limit drops below the resident count: nothing is flushed
  // and misses keep replacing the back entry.
  stim_row_t directed_rows [ROWS] = '{
    '{ROW_LIMIT, 4'd0,  20'h00000, 1'b0, lrupr_pkg::OUTCOME_HIT,     3'd0, 20'h00000},
    '{ROW_PAGE,  4'd0,  20'h00000, 1'b1, lrupr_pkg::OUTCOME_FILL,    3'd0, 20'h00000},
    '{ROW_PAGE,  4'd0,  20'hFFFFF, 1'b1, lrupr_pkg::OUTCOME_REPLACE, 3'd0, 20'h00000},
    '{ROW_PAGE,  4'd0,  20'hFFFFF, 1'b1, lrupr_pkg::OUTCOME_HIT,     3'd0, 20'h00000},
    '{ROW_PAGE,  4'd0,  20'h00000, 1'b1, lrupr_pkg::OUTCOME_REPLACE, 3'd0, 20'hFFFFF},
    '{ROW_LIMIT, 4'd15, 20'h00000, 1'b0, lrupr_pkg::OUTCOME_HIT,     3'd0, 20'h00000},
    '{ROW_PAGE,  4'd0,  20'hFFFFF, 1'b1, lrupr_pkg::OUTCOME_FILL,    3'd1, 20'h00000},
    '{ROW_PAGE,  4'd0,  20'h00000, 1'b1, lrupr_pkg::OUTCOME_HIT,     3'd0, 20'h00000},
    '{ROW_PAGE,  4'd0,  20'h55555, 1'b1, lrupr_pkg::OUTCOME_FILL,    3'd2, 20'h00000},
    '{ROW_PAGE,  4'd0,  20'hAAAAA, 1'b1, lrupr_pkg::OUTCOME_FILL,    3'd3, 20'h00000},
    '{ROW_PAGE,  4'd0,  20'h00001, 1'b1, lrupr_pkg::OUTCOME_FILL,    3'd4, 20'h00000},
    '{ROW_PAGE,  4'd0,  20'h00002, 1'b1, lrupr_pkg::OUTCOME_FILL,    3'd5, 20'h00000},
    '{ROW_PAGE,  4'd0,  20'h80000, 1'b1, lrupr_pkg::OUTCOME_FILL,    3'd6, 20'h00000},
    '{ROW_PAGE,  4'd0,  20'h7FFFF, 1'b1, lrupr_pkg::OUTCOME_FILL,    3'd7, 20'h00000},
    '{ROW_PAGE,  4'd0,  20'h12345, 1'b1, lrupr_pkg::OUTCOME_REPLACE, 3'd1, 20'hFFFFF},
    '{ROW_PAGE,  4'd0,  20'h00000, 1'b1, lrupr_pkg::OUTCOME_HIT,     3'd0, 20'h00000},
    '{ROW_PAGE,  4'd0,  20'h00002, 1'b0, lrupr_pkg::OUTCOME_HIT,     3'd0, 20'h00000},
    '{ROW_LIMIT, 4'd2,  20'h00000, 1'b0, lrupr_pkg::OUTCOME_HIT,     3'd0, 20'h00000},
    '{ROW_PAGE,  4'd0,  20'h00003, 1'b1, lrupr_pkg::OUTCOME_REPLACE, 3'd2, 20'h55555},
    '{ROW_PAGE,  4'd0,  20'h00003, 1'b0, lrupr_pkg::OUTCOME_HIT,     3'd0, 20'h00000},
    '{ROW_PAGE,  4'd0,  20'h7FFFF, 1'b0, lrupr_pkg::OUTCOME_HIT,     3'd0, 20'h00000},
    '{ROW_PAGE,  4'd0,  20'h00004, 1'b0, lrupr_pkg::OUTCOME_HIT,     3'd0, 20'h00000}
  };

  lru_page_replacement #(
    .FRAMES(FRAMES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .page_number(page_number),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .outcome(outcome),
    .frame(frame),
    .evicted_page(evicted_page),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .frame_limit(frame_limit)
  );

  always #5 clk = ~clk;

  // Run guard: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Looks up one page in the mirrored recency list, updates the list the way
  // the block must, and returns the result the block owes for it.
  function automatic result_t lru_lookup(lrupr_pkg::page_t p);
    result_t r;
    int n;
    int cap;
    int hit_at;
    int pos;
    int i;
    r = '0;
    n = (resident_n > FRAMES) ? FRAMES : resident_n;
    cap = int'(limit_reg);
    if (cap < 1) cap = 1;
    if (cap > FRAMES) cap = FRAMES;
    hit_at = -1;
    for (i = 0; i < n; i++) begin
      if (hit_at < 0 && resident_pages[i] == p) hit_at = i;
    end
    if (hit_at >= 0) begin
      r.outcome = lrupr_pkg::OUTCOME_HIT;
      r.frame = resident_frames[hit_at];
      pos = hit_at;
    end else if (n < cap) begin
      // Free frames are handed out in order, so the count names the frame.
      r.outcome = lrupr_pkg::OUTCOME_FILL;
      r.frame = lrupr_pkg::frame_t'(n);
      pos = n;
      resident_n = n + 1;
    end else begin
      // The back entry loses its frame to the new page. With the limit
      // lowered below the count this is still the last resident entry.
      r.outcome = lrupr_pkg::OUTCOME_REPLACE;
      r.evicted = resident_pages[n - 1];
      r.frame = resident_frames[n - 1];
      pos = n - 1;
    end
    for (i = pos; i > 0; i--) begin
      resident_pages[i] = resident_pages[i - 1];
      resident_frames[i] = resident_frames[i - 1];
    end
    resident_pages[0] = p;
    resident_frames[0] = r.frame;
    return r;
  endfunction

  task automatic flag_mismatch(string field, int unsigned want, int unsigned got);
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    mismatches++;
  endtask

  // Every handshake is sampled at the rising edge, before any of the
  // nonblocking updates made at that edge land.
  always @(posedge clk) begin
    result_t predicted;
    result_t want;
    if (rst) begin
      foreach (resident_pages[i]) begin
        resident_pages[i] = '0;
        resident_frames[i] = '0;
      end
      resident_n = 0;
      limit_reg = lrupr_pkg::LIMIT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) limit_reg = frame_limit;
      if (in_valid && in_ready) begin
        predicted = lru_lookup(page_number);
        pending_lookups.push_back(pin_valid ? pin_result : predicted);
      end
      if (out_valid && out_ready) begin
        if (pending_lookups.size() == 0) begin
          $display("%0t: result with nothing expected, outcome %0d frame %0d",
                   $time, outcome, frame);
          mismatches++;
        end else begin
          want = pending_lookups.pop_front();
          if (outcome !== want.outcome) begin
            flag_mismatch("outcome", 32'(want.outcome), 32'(outcome));
          end
          if (frame !== want.frame) begin
            flag_mismatch("frame", 32'(want.frame), 32'(frame));
          end
          if (evicted_page !== want.evicted) begin
            flag_mismatch("evicted_page", 32'(want.evicted), 32'(evicted_page));
          end
        end
      end
    end
  end

  // Result side. Takes random breaks at the current idle rate, and on request
  // holds off for one long stretch so the block backs up into its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_requested) begin
        hold_requested = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offers one page request, sometimes after a few idle cycles, and returns
  // at the edge where it is taken. Valid stays high for a request that
  // follows at once.
  task automatic send_page(lrupr_pkg::page_t p, logic pinned, result_t want);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    page_number <= p;
    pin_valid <= pinned;
    pin_result <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering requests and waits for every owed result. The queue is
  // looked at on the falling edge, clear of the checker's updates.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_lookups.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // The limit is only changed with the block idle.
  task automatic write_limit(lrupr_pkg::limit_t value);
    pause_until_drained();
    cfg_valid <= 1'b1;
    frame_limit <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly pages from a small pool, so the eight-entry list sees plenty of
  // hits at every depth; the rest are arbitrary pages that force misses.
  function automatic lrupr_pkg::page_t pick_page();
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) begin
      page_pool[$urandom_range(POOL_N - 1)] = lrupr_pkg::page_t'($urandom_range(20'hFFFFF));
    end
    if (roll < 65) return page_pool[$urandom_range(POOL_N - 1)];
    if (roll < 70) return (roll[0]) ? 20'hFFFFF : 20'h00000;
    return lrupr_pkg::page_t'($urandom_range(20'hFFFFF));
  endfunction

  initial begin
    lrupr_pkg::limit_t phase_limit [3];
    phase_limit = '{4'd8, 4'd1, 4'd15};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_LIMIT) begin
        write_limit(directed_rows[k].limit);
      end else begin
        send_page(directed_rows[k].page, directed_rows[k].pinned,
                  '{directed_rows[k].outcome, directed_rows[k].frame,
                    directed_rows[k].evicted});
      end
    end

    // Three random phases: a slow receiver, then a slow sender, then both at
    // full speed with one long receiver hold-off at the start.
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 75 : 0;
      rx_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 20 : 0;
      write_limit(phase_limit[ph]);
      foreach (page_pool[j]) page_pool[j] = lrupr_pkg::page_t'($urandom_range(20'hFFFFF));
      page_pool[0] = 20'h00000;
      page_pool[1] = 20'hFFFFF;
      if (ph == 2) hold_requested = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == PHASE_ITEMS / 2) pause_until_drained();
        send_page(pick_page(), 1'b0, '0);
      end
    end

    pause_until_drained();
    repeat (FRAMES + 4) @(posedge clk);
    if (mismatches == 0 && pending_lookups.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
